>>> design/cic_pkg.sv
// ----------------------------------------------------------------------------
// CIC I/Q decimator package
// Shared widths, register indexes and the integrator/comb cell control type.
// ----------------------------------------------------------------------------
package cic_pkg;

    localparam int MAX_STAGES = 8;
    localparam int ACC_W      = 64;
    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 8;
    localparam int RATIO_W    = 7;
    localparam int STAGES_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int STG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION_RATIO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT      = 1'b1;

    localparam logic signed [ACC_W-1:0] SAT_HIGH = 64'sd127;
    localparam logic signed [ACC_W-1:0] SAT_LOW  = -64'sd128;

    typedef logic [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic active;
        logic load;
    } cell_ctrl_t;

endpackage

>>> design/cic_cell.sv
// ----------------------------------------------------------------------------
// CIC cell
// One stage of the chain for both channels. In integrate mode it adds the
// value from its left neighbor into its integrator; in comb mode it subtracts
// its stored delay from the value passed along and stores that value.
// ----------------------------------------------------------------------------
module cic_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  cic_pkg::cell_ctrl_t ctrl,
    input  logic                comb_mode,
    input  cic_pkg::acc_t       in_i,
    input  cic_pkg::acc_t       in_q,
    output cic_pkg::acc_t       out_i,
    output cic_pkg::acc_t       out_q
);
    import cic_pkg::*;

    acc_t integ_i_reg, integ_q_reg, integ_i_next, integ_q_next;
    acc_t delay_i_reg, delay_q_reg, delay_i_next, delay_q_next;

    always_comb begin
        integ_i_next = integ_i_reg;
        integ_q_next = integ_q_reg;
        delay_i_next = delay_i_reg;
        delay_q_next = delay_q_reg;
        if (ctrl.active && ctrl.load) begin
            if (comb_mode) begin
                delay_i_next = in_i;
                delay_q_next = in_q;
            end else begin
                integ_i_next = integ_i_reg + in_i;
                integ_q_next = integ_q_reg + in_q;
            end
        end
    end

    always_comb begin
        if (!ctrl.active) begin
            out_i = in_i;
            out_q = in_q;
        end else if (comb_mode) begin
            out_i = in_i - delay_i_reg;
            out_q = in_q - delay_q_reg;
        end else begin
            out_i = integ_i_next;
            out_q = integ_q_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_i_reg <= '0;
            integ_q_reg <= '0;
            delay_i_reg <= '0;
            delay_q_reg <= '0;
        end else begin
            integ_i_reg <= integ_i_next;
            integ_q_reg <= integ_q_next;
            delay_i_reg <= delay_i_next;
            delay_q_reg <= delay_q_next;
        end
    end

endmodule

>>> design/cic_div.sv
// ----------------------------------------------------------------------------
// CIC gain divider
// Restoring divider, one quotient bit per cycle, for both channels, then
// truncation toward zero and saturation to eight bits.
// ----------------------------------------------------------------------------
module cic_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  cic_pkg::acc_t          num_i,
    input  cic_pkg::acc_t          num_q,
    input  cic_pkg::acc_t          divisor,
    output logic                   done,
    output logic [cic_pkg::OUT_W-1:0] res_i,
    output logic [cic_pkg::OUT_W-1:0] res_q
);
    import cic_pkg::*;

    logic       busy_reg, busy_next;
    logic [6:0] cnt_reg, cnt_next;
    acc_t       div_reg;
    acc_t       qi_reg, qq_reg, ri_reg, rq_reg;
    logic       ni_reg, nq_reg;
    acc_t       ri_sh, rq_sh;
    logic       ge_i, ge_q;
    acc_t       qi_s, qq_s;

    assign ri_sh = {ri_reg[ACC_W-2:0], qi_reg[ACC_W-1]};
    assign rq_sh = {rq_reg[ACC_W-2:0], qq_reg[ACC_W-1]};
    assign ge_i  = ri_sh >= div_reg;
    assign ge_q  = rq_sh >= div_reg;
    assign busy_next = start ? 1'b1 : (busy_reg && cnt_reg != 7'd1);
    assign cnt_next  = start ? 7'(ACC_W) : (busy_reg ? cnt_reg - 7'd1 : cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done     <= busy_reg && cnt_reg == 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= divisor;
            ni_reg  <= num_i[ACC_W-1];
            nq_reg  <= num_q[ACC_W-1];
            qi_reg  <= num_i[ACC_W-1] ? -num_i : num_i;
            qq_reg  <= num_q[ACC_W-1] ? -num_q : num_q;
            ri_reg  <= '0;
            rq_reg  <= '0;
        end else if (busy_reg) begin
            ri_reg <= ge_i ? ri_sh - div_reg : ri_sh;
            rq_reg <= ge_q ? rq_sh - div_reg : rq_sh;
            qi_reg <= {qi_reg[ACC_W-2:0], ge_i};
            qq_reg <= {qq_reg[ACC_W-2:0], ge_q};
        end
    end

    assign qi_s = ni_reg ? -qi_reg : qi_reg;
    assign qq_s = nq_reg ? -qq_reg : qq_reg;

    always_comb begin
        if ($signed(qi_s) > SAT_HIGH)     res_i = SAT_HIGH[OUT_W-1:0];
        else if ($signed(qi_s) < SAT_LOW) res_i = SAT_LOW[OUT_W-1:0];
        else                              res_i = qi_s[OUT_W-1:0];
        if ($signed(qq_s) > SAT_HIGH)     res_q = SAT_HIGH[OUT_W-1:0];
        else if ($signed(qq_s) < SAT_LOW) res_q = SAT_LOW[OUT_W-1:0];
        else                              res_q = qq_s[OUT_W-1:0];
    end

    assert property (@(posedge aclk) disable iff (!aresetn) start |=> busy_reg)
        else $error("divider did not start");
    assert property (@(posedge aclk) disable iff (!aresetn) done |-> !busy_reg)
        else $error("done while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != 7'd0)
        else $error("divider count underflow");

endmodule

>>> design/cic_iq_decimator_top.sv
// ----------------------------------------------------------------------------
// CIC I/Q decimator top level
// Eight integrator/comb cells in a chain, a gain multiplier and a divider.
// ----------------------------------------------------------------------------
// Input transactions carry one I/Q sample on s_in_i/s_in_q. Each sample enters
// the cell chain and advances one cell per cycle, and integrate-only inputs are
// taken at one per cycle. Every decimation_ratio-th input also yields one
// transaction on m_out_i/m_out_q. After such an input, s_ready drops: its
// sample finishes the integrator pass, is sent back through the same cells for
// the comb pass, the gain R^N is formed by one multiply per cycle, and both
// channels are divided in a bit-serial divider. The output register holds a
// result until m_ready; the next inputs are taken while it waits, but a further
// result holds before the divider until the register is free.
// Reset clears all integrators, comb delays and the phase counter, and sets
// ratio and stage count to 1. Configuration writes on cfg_* take effect at
// once; they are to be made only while the block is idle, which the block
// itself does not enforce.
// ----------------------------------------------------------------------------
module cic_iq_decimator_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [cic_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cic_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [cic_pkg::SAMPLE_W-1:0] s_in_i,
    input  logic signed [cic_pkg::SAMPLE_W-1:0] s_in_q,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [cic_pkg::OUT_W-1:0]  m_out_i,
    output logic signed [cic_pkg::OUT_W-1:0]  m_out_q
);
    import cic_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INTEG = 3'd1;
    localparam logic [2:0] ST_COMB  = 3'd2;
    localparam logic [2:0] ST_GAIN  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [RATIO_W-1:0]  ratio_reg, phase_reg;
    logic [STAGES_W-1:0] stages_reg, gcnt_reg;
    logic [STG_IDX_W:0]  n_act;
    logic [RATIO_W-1:0]  r_act;
    logic [RATIO_W-1:0]  phase_inc;
    acc_t                gain_reg, hold_i_reg, hold_q_reg;
    logic                accept, fire, inject, comb_done, div_done, out_full_reg;
    logic [OUT_W-1:0]    res_i, res_q;

    acc_t       link_i_reg  [MAX_STAGES+1];
    acc_t       link_q_reg  [MAX_STAGES+1];
    logic       link_v_reg  [MAX_STAGES+1];
    logic       link_c_reg  [MAX_STAGES+1];
    logic       link_f_reg  [MAX_STAGES+1];
    acc_t       link_i_next [MAX_STAGES];
    acc_t       link_q_next [MAX_STAGES];
    cell_ctrl_t ctrl        [MAX_STAGES];

    assign n_act = (stages_reg > STAGES_W'(MAX_STAGES)) ? (STG_IDX_W+1)'(MAX_STAGES)
                                                        : stages_reg[STG_IDX_W:0];
    assign r_act = (ratio_reg == '0) ? RATIO_W'(1) : ratio_reg;
    assign phase_inc = phase_reg + RATIO_W'(1);

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign fire    = accept && (phase_inc >= r_act);

    assign inject    = (state_reg == ST_INTEG) && link_v_reg[MAX_STAGES]
                       && link_f_reg[MAX_STAGES];
    assign comb_done = (state_reg == ST_COMB) && link_v_reg[MAX_STAGES]
                       && link_c_reg[MAX_STAGES];

    genvar g;
    generate
        for (g = 0; g < MAX_STAGES; g++) begin : g_cell
            assign ctrl[g].active = (STG_IDX_W+1)'(g) < n_act;
            assign ctrl[g].load   = link_v_reg[g];
            cic_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl[g]),
                .comb_mode(link_c_reg[g]),
                .in_i(link_i_reg[g]), .in_q(link_q_reg[g]),
                .out_i(link_i_next[g]), .out_q(link_q_next[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= MAX_STAGES; k++) begin
                link_v_reg[k] <= 1'b0;
                link_c_reg[k] <= 1'b0;
                link_f_reg[k] <= 1'b0;
            end
        end else begin
            link_v_reg[0] <= accept || inject;
            link_c_reg[0] <= inject;
            link_f_reg[0] <= fire || inject;
            for (int k = 0; k < MAX_STAGES; k++) begin
                link_v_reg[k+1] <= link_v_reg[k];
                link_c_reg[k+1] <= link_c_reg[k];
                link_f_reg[k+1] <= link_f_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (inject) begin
            link_i_reg[0] <= link_i_reg[MAX_STAGES];
            link_q_reg[0] <= link_q_reg[MAX_STAGES];
        end else if (accept) begin
            link_i_reg[0] <= ACC_W'($signed(s_in_i));
            link_q_reg[0] <= ACC_W'($signed(s_in_q));
        end
        for (int k = 0; k < MAX_STAGES; k++) begin
            link_i_reg[k+1] <= link_i_next[k];
            link_q_reg[k+1] <= link_q_next[k];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (fire) state_next = ST_INTEG;
            ST_INTEG: if (inject) state_next = ST_COMB;
            ST_COMB:  if (comb_done) state_next = ST_GAIN;
            ST_GAIN:  if (gcnt_reg == '0 && !out_full_reg) state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ratio_reg    <= RATIO_W'(1);
            stages_reg   <= STAGES_W'(1);
            phase_reg    <= '0;
            gcnt_reg     <= '0;
            out_full_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == REG_DECIMATION_RATIO) ratio_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_STAGE_COUNT)
                stages_reg <= cfg_data[STAGES_W-1:0];
            if (accept) phase_reg <= fire ? '0 : phase_inc;
            if (comb_done) gcnt_reg <= STAGES_W'(n_act);
            else if (state_reg == ST_GAIN && gcnt_reg != '0)
                gcnt_reg <= gcnt_reg - STAGES_W'(1);
            if (div_done) out_full_reg <= 1'b1;
            else if (m_valid && m_ready) out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (comb_done) begin
            hold_i_reg <= link_i_reg[MAX_STAGES];
            hold_q_reg <= link_q_reg[MAX_STAGES];
        end
        if (comb_done) gain_reg <= ACC_W'(1);
        else if (state_reg == ST_GAIN && gcnt_reg != '0)
            gain_reg <= gain_reg * ACC_W'(r_act);
        if (div_done) begin
            m_out_i <= res_i;
            m_out_q <= res_q;
        end
    end

    cic_div u_div (
        .aclk(aclk), .aresetn(aresetn),
        .start(state_reg == ST_GAIN && gcnt_reg == '0 && !out_full_reg),
        .num_i(hold_i_reg), .num_q(hold_q_reg), .divisor(gain_reg),
        .done(div_done), .res_i(res_i), .res_q(res_q)
    );

    assign m_valid = out_full_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> state_reg == ST_INTEG)
        else $error("integrator pass skipped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> !out_full_reg)
        else $error("result overwritten");
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !fire |=> phase_reg == $past(phase_inc))
        else $error("phase count slip");

endmodule

>>> sim/cic_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CIC I/Q decimator checker
// Watches the configuration port and both channels, keeps its own copy of the
// integrator/comb state, predicts each decimated sample and compares it with
// what the block puts out.
// ----------------------------------------------------------------------------
module cic_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [cic_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [cic_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  logic signed [cic_pkg::SAMPLE_W-1:0]    s_in_i,
    input  logic signed [cic_pkg::SAMPLE_W-1:0]    s_in_q,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic signed [cic_pkg::OUT_W-1:0]       m_out_i,
    input  logic signed [cic_pkg::OUT_W-1:0]       m_out_q,
    output int                                     fail_count,
    output int                                     pending,
    output int                                     result_count
);
    import cic_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0] oi;
        logic signed [OUT_W-1:0] oq;
    } iq_out_t;

    logic [RATIO_W-1:0]  ratio_reg;
    logic [STAGES_W-1:0] stages_reg;
    acc_t integ_i [MAX_STAGES];
    acc_t integ_q [MAX_STAGES];
    acc_t delay_i [MAX_STAGES];
    acc_t delay_q [MAX_STAGES];
    logic [RATIO_W-1:0] phase;
    iq_out_t decimated_q[$];

    function automatic logic signed [OUT_W-1:0] clip8(input logic signed [ACC_W-1:0] v);
        if (v > SAT_HIGH) return 8'sd127;
        if (v < SAT_LOW) return -8'sd128;
        return v[OUT_W-1:0];
    endfunction

    task automatic integrate_sample(input logic signed [SAMPLE_W-1:0] xi,
                                    input logic signed [SAMPLE_W-1:0] xq);
        int n;
        acc_t yi, yq, pi, pq;
        logic [ACC_W-1:0] r, gain;
        logic signed [ACC_W-1:0] di, dq;
        iq_out_t e;
        n = (stages_reg > MAX_STAGES) ? MAX_STAGES : int'(stages_reg);
        r = (ratio_reg == 0) ? 64'd1 : 64'(ratio_reg);
        yi = {{(ACC_W-SAMPLE_W){xi[SAMPLE_W-1]}}, xi};
        yq = {{(ACC_W-SAMPLE_W){xq[SAMPLE_W-1]}}, xq};
        for (int s = 0; s < n; s++) begin
            integ_i[s] = integ_i[s] + yi;
            integ_q[s] = integ_q[s] + yq;
            yi = integ_i[s];
            yq = integ_q[s];
        end
        phase = phase + 1'b1;
        if (64'(phase) < r) return;
        phase = '0;
        for (int s = 0; s < n; s++) begin
            pi = delay_i[s];
            pq = delay_q[s];
            delay_i[s] = yi;
            delay_q[s] = yq;
            yi = yi - pi;
            yq = yq - pq;
        end
        gain = 64'd1;
        for (int s = 0; s < n; s++) gain = gain * r;
        di = $signed(yi) / $signed(gain);
        dq = $signed(yq) / $signed(gain);
        e.oi = clip8(di);
        e.oq = clip8(dq);
        decimated_q.push_back(e);
    endtask

    always @(posedge aclk) begin
        iq_out_t e;
        if (!aresetn) begin
            ratio_reg  <= RATIO_W'(1);
            stages_reg <= STAGES_W'(1);
            phase = '0;
            for (int s = 0; s < MAX_STAGES; s++) begin
                integ_i[s] = '0; integ_q[s] = '0; delay_i[s] = '0; delay_q[s] = '0;
            end
            decimated_q.delete();
            fail_count   <= 0;
            result_count <= 0;
        end else begin
            if (s_valid && s_ready) integrate_sample(s_in_i, s_in_q);
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (decimated_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected transaction: i=%0d q=%0d", m_out_i, m_out_q);
                    fail_count <= fail_count + 1;
                end else begin
                    e = decimated_q.pop_front();
                    if (e.oi !== m_out_i || e.oq !== m_out_q) begin
                        if (fail_count < 10)
                            $display("mismatch: expected i=%0d q=%0d, got i=%0d q=%0d",
                                     e.oi, e.oq, m_out_i, m_out_q);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == REG_DECIMATION_RATIO) ratio_reg <= cfg_data[RATIO_W-1:0];
                else if (cfg_index == REG_STAGE_COUNT) stages_reg <= cfg_data[STAGES_W-1:0];
            end
        end
        pending = decimated_q.size();
    end
endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CIC I/Q decimator testbench
// Drives directed and random I/Q bursts across several ratio/stage settings,
// with random receiver stalls and one long hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import cic_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_DECIMATION_RATIO;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SAMPLE_W-1:0] s_in_i = '0;
    logic signed [SAMPLE_W-1:0] s_in_q = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_out_i;
    logic signed [OUT_W-1:0] m_out_q;
    int fail_count, pending, result_count;
    int cycle_count = 0;
    int sample_count = 0;
    int hold_off = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int setting_count = 0;
    bit stall_mode = 1'b0;

    always #10 aclk = ~aclk;

    cic_iq_decimator_top uut (.*);

    cic_checker chk (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("[cic_iq_decimator_top] ERROR");
            $finish;
        end
    end

    // receiver: random stall pattern, plus a long hold-off when requested
    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_off <= 400;
            m_ready  <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready  <= 1'b0;
        end else if (stall_mode) begin
            m_ready <= ($urandom_range(0, 3) == 0);
        end else begin
            m_ready <= ($urandom_range(0, 9) != 0);
        end
    end

    always @(posedge aclk) if (cycle_count % 500 == 0) stall_mode <= $urandom_range(0, 1);

    task automatic send_sample(input logic [SAMPLE_W-1:0] xi, input logic [SAMPLE_W-1:0] xq);
        s_valid <= 1'b1;
        s_in_i  <= xi;
        s_in_q  <= xq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sample_count++;
        @(negedge aclk);
    endtask

    task automatic idle_gap(input int n);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic drain_and_idle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input int r, input int n);
        drain_and_idle();
        write_reg(REG_DECIMATION_RATIO, r);
        write_reg(REG_STAGE_COUNT, n);
        setting_count++;
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic random_bursts(input int count);
        int left, burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            if (burst > left) burst = left;
            repeat (burst) send_sample(rand_sample(), rand_sample());
            left -= burst;
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
        end
    endtask

    initial begin
        int cfgs [10][2] = '{'{1, 1}, '{64, 8}, '{2, 3}, '{64, 1}, '{1, 8},
                             '{5, 4}, '{16, 2}, '{3, 8}, '{8, 6}, '{7, 5}};
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // directed: extremes at reset settings, then at deep settings
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h0000, 16'hFFFF);
        send_sample(16'h0001, 16'h0000);
        configure(4, 2);
        repeat (8) send_sample(16'h7FFF, 16'h8000);
        repeat (8) send_sample(16'h8000, 16'h7FFF);
        configure(1, 8);
        repeat (4) send_sample(16'h7FFF, 16'h7FFF);
        // long receiver hold-off while the sender keeps offering
        drain_and_idle();
        hold_req++;
        random_bursts(60);
        for (int k = 0; k < 10; k++) begin
            configure(cfgs[k][0], cfgs[k][1]);
            random_bursts(cfgs[k][0] >= 16 ? 400 : 100);
        end
        drain_and_idle();
        $display("covered %0d samples, %0d decimated results over %0d settings",
                 sample_count, result_count, setting_count);
        if (fail_count == 0) begin
            $display("[cic_iq_decimator_top] OK");
        end else begin
            $display("[cic_iq_decimator_top] ERROR");
        end
        $finish;
    end
endmodule
